// ----- rtl/psrd_pkg.sv -----
// ----------------------------------------------------------------------------
// Port scan rate detector package
// Shared widths, reset values, register indexes and the bitmap word size.
// ----------------------------------------------------------------------------
package psrd_pkg;

	// default size of each seen-port bitmap
	localparam int unsigned PORT_TABLE_SIZE_DEF = 4096;

	// bitmap memory word: 32 port bits per row
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W  = 5;

	// field widths
	localparam int unsigned PORT_W     = 16;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned MAX_NEW_W  = 14;
	localparam int unsigned DURATION_W = 16;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_NEW_PORTS  = 4'd0,
		CFG_BLOCK_DURATION = 4'd1
	} cfg_reg_t;

	// reset values and limits
	localparam logic [MAX_NEW_W-1:0]  MAX_NEW_RESET  = 14'd100;
	localparam logic [DURATION_W-1:0] DURATION_RESET = 16'd10;
	localparam logic [MAX_NEW_W-1:0]  COUNT_MAX      = 14'h3FFF;

endpackage

// ----- rtl/port_scan_rate_detector_unit.sv -----
// ----------------------------------------------------------------------------
// Port scan rate detector
// Per-packet seen-port check with a per-second new-port limit and drop window.
// ----------------------------------------------------------------------------
// Usage:
//   pkt channel (valid/ready) carries is_tcp, dst_port, now_seconds.
//   res channel (valid/ready) returns drop and scan_newly_detected, one per packet.
//   cfg channel (valid/ready, always ready) writes register cfg_index with cfg_data;
//   write it only while the block is idle.
// Packet flow:
//   Both bitmaps share one memory of 32-bit rows with a registered read. A packet
//   passes the idle state where it is taken and a read-modify-write state when
//   PORT_TABLE_SIZE is a power of two, plus a lookup state otherwise that reduces the port modulo the size.
//   The result sits in an output register; the next packet is taken while it waits.
// Map clear:
//   A new-port packet in a newer second clears both bitmaps with a sweep over all
//   2 * 2^max(1, ceil(log2(ceil(PORT_TABLE_SIZE/32)))) rows (256 at the default
//   size), one row per cycle, during which no packet is taken. Reset runs the same sweep.
// Stall:
//   While the receiver holds res_ready low with a result pending, the next packet
//   waits in its update cycle and pkt_ready stays low.
// ----------------------------------------------------------------------------
module port_scan_rate_detector_unit #(
	parameter int unsigned PORT_TABLE_SIZE = psrd_pkg::PORT_TABLE_SIZE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// packet channel
	input  logic                              pkt_valid,
	output logic                              pkt_ready,
	input  logic                              is_tcp,
	input  logic [psrd_pkg::PORT_W-1:0]       dst_port,
	input  logic [psrd_pkg::TIME_W-1:0]       now_seconds,
	// result channel
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic                              drop,
	output logic                              scan_newly_detected,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [psrd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [psrd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned WORD_W       = psrd_pkg::WORD_W;
	localparam int unsigned BIT_W        = psrd_pkg::BIT_W;
	localparam int unsigned ROWS_PER_MAP = (PORT_TABLE_SIZE + WORD_W - 1) / WORD_W;
	localparam int unsigned ROW_W        = (ROWS_PER_MAP > 1) ? $clog2(ROWS_PER_MAP) : 1;
	localparam int unsigned ADDR_W       = ROW_W + 1;
	localparam int unsigned IDX_W        = ROW_W + BIT_W;
	localparam bit          IS_POW2      = (PORT_TABLE_SIZE & (PORT_TABLE_SIZE - 1)) == 0;
	// reciprocal for the port modulo: floor(2^32 / size)
	localparam logic [31:0] RECIP        = 32'(64'h1_0000_0000 / PORT_TABLE_SIZE);
	localparam logic [16:0] TABLE_SIZE_C = 17'(PORT_TABLE_SIZE);

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_LOOK,
		S_UPD
	} state_t;

	state_t state_q;

	// control and architectural state
	logic [ADDR_W-1:0]                  clr_q;
	logic                               res_valid_q;
	logic                               drop_q;
	logic                               newly_q;
	logic [psrd_pkg::TIME_W-1:0]        last_second_q;
	logic [psrd_pkg::TIME_W-1:0]        window_start_q;
	logic [psrd_pkg::MAX_NEW_W-1:0]     count_q;
	logic                               scan_flag_q;
	logic [psrd_pkg::MAX_NEW_W-1:0]     max_new_q;
	logic [psrd_pkg::DURATION_W-1:0]    duration_q;

	// captured packet
	logic                               tcp_q;
	logic [psrd_pkg::PORT_W-1:0]        port_q;
	logic [psrd_pkg::TIME_W-1:0]        now_q;
	logic [IDX_W-1:0]                   idx_q;
	logic [47:0]                        prod_s1;

	// memory interface
	logic                               ram_we;
	logic [ADDR_W-1:0]                  ram_waddr;
	logic [WORD_W-1:0]                  ram_wdata;
	logic                               ram_re;
	logic [ADDR_W-1:0]                  ram_raddr;
	logic [WORD_W-1:0]                  ram_rdata;

	// datapath
	logic                               pkt_fire;
	logic                               res_free;
	logic                               upd_go;
	logic [IDX_W-1:0]                   idx_pow2;
	logic [15:0]                        quot;
	logic [16:0]                        quot_mul;
	logic [16:0]                        rem;
	logic [16:0]                        rem_fix;
	logic [IDX_W-1:0]                   idx_gen;
	logic                               hit;
	logic                               new_sec;
	logic [psrd_pkg::MAX_NEW_W-1:0]     count_inc;
	logic                               over;
	logic [psrd_pkg::TIME_W-1:0]        window_next;
	logic                               flag_set;
	logic [psrd_pkg::TIME_W:0]          window_end;
	logic                               drop_d;

	// handshakes
	assign pkt_ready = (state_q == S_IDLE);
	assign pkt_fire  = pkt_valid && pkt_ready;
	assign cfg_ready = 1'b1;
	assign res_free  = !res_valid_q || res_ready;
	assign upd_go    = (state_q == S_UPD) && res_free;

	assign res_valid           = res_valid_q;
	assign drop                = drop_q;
	assign scan_newly_detected = newly_q;

	// reduce the port to a table index: mask for power-of-two sizes
	assign idx_pow2 = IDX_W'({1'b0, dst_port} & (TABLE_SIZE_C - 17'd1));

	// reduce by reciprocal multiply with one correction step otherwise
	always_comb begin
		quot     = prod_s1[47:32];
		quot_mul = 17'(33'(quot) * 33'(TABLE_SIZE_C));
		rem      = {1'b0, port_q} - quot_mul;
		rem_fix  = (rem >= TABLE_SIZE_C) ? (rem - TABLE_SIZE_C) : rem;
		idx_gen  = IDX_W'(rem_fix);
	end

	// decide the packet from the row just read
	always_comb begin
		hit         = ram_rdata[idx_q[BIT_W-1:0]];
		new_sec     = now_q > last_second_q;
		count_inc   = (count_q < psrd_pkg::COUNT_MAX) ? (count_q + 1'b1) : count_q;
		over        = count_inc > max_new_q;
		window_next = (!new_sec && over) ? now_q : window_start_q;
		flag_set    = !new_sec && over && !scan_flag_q;
		window_end  = {1'b0, window_next} + (psrd_pkg::TIME_W + 1)'(duration_q);
		drop_d      = {1'b0, now_q} < window_end;
	end

	// memory access: clear sweep, bit write-back, lookups
	always_comb begin
		ram_we    = (state_q == S_CLR) || (upd_go && !hit && !new_sec);
		ram_waddr = (state_q == S_CLR) ? clr_q : {tcp_q, idx_q[IDX_W-1:BIT_W]};
		ram_wdata = (state_q == S_CLR) ? '0
			: (ram_rdata | (WORD_W'(1) << idx_q[BIT_W-1:0]));
		ram_re    = (pkt_fire && IS_POW2) || (state_q == S_LOOK);
		ram_raddr = (state_q == S_LOOK) ? {tcp_q, idx_gen[IDX_W-1:BIT_W]}
			: {is_tcp, idx_pow2[IDX_W-1:BIT_W]};
	end

	psrd_seen_ram #(
		.ADDR_W (ADDR_W)
	) u_seen_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capture the packet and its index
	always_ff @(posedge clk) begin
		if (pkt_fire) begin
			tcp_q   <= is_tcp;
			port_q  <= dst_port;
			now_q   <= now_seconds;
			prod_s1 <= 48'(dst_port) * 48'(RECIP);
			idx_q   <= idx_pow2;
		end else if (state_q == S_LOOK) begin
			idx_q   <= idx_gen;
		end
	end

	// sequence the packet, hold the detector state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			clr_q          <= '0;
			res_valid_q    <= 1'b0;
			drop_q         <= 1'b0;
			newly_q        <= 1'b0;
			last_second_q  <= '0;
			window_start_q <= '0;
			count_q        <= '0;
			scan_flag_q    <= 1'b0;
			max_new_q      <= psrd_pkg::MAX_NEW_RESET;
			duration_q     <= psrd_pkg::DURATION_RESET;
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					psrd_pkg::CFG_MAX_NEW_PORTS: begin
						max_new_q <= cfg_data[psrd_pkg::MAX_NEW_W-1:0];
					end
					psrd_pkg::CFG_BLOCK_DURATION: begin
						duration_q <= cfg_data[psrd_pkg::DURATION_W-1:0];
					end
					default: begin
					end
				endcase
			end

			// raise the result when an update completes, drop it once transferred
			if (upd_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {ADDR_W{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pkt_fire) begin
						state_q <= IS_POW2 ? S_UPD : S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (res_free) begin
						if (!hit && new_sec) begin
							state_q <= S_CLR;
						end else begin
							state_q <= S_IDLE;
						end
						if (hit) begin
							drop_q  <= 1'b0;
							newly_q <= 1'b0;
						end else begin
							drop_q         <= drop_d;
							newly_q        <= flag_set;
							window_start_q <= window_next;
							scan_flag_q    <= drop_d ? (scan_flag_q | flag_set) : 1'b0;
							if (new_sec) begin
								last_second_q <= now_q;
								count_q       <= {{(psrd_pkg::MAX_NEW_W-1){1'b0}}, 1'b1};
							end else begin
								count_q <= count_inc;
							end
						end
					end
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// a lookup never shares a cycle with a bitmap write
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("bitmap read and write in the same cycle");

	// a result only comes out of an update cycle
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_UPD))
		else $error("result raised outside an update");

	// a new second starts a full sweep from the first row
	a_clear_on_new_second: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && !hit && new_sec) |=> (state_q == S_CLR && clr_q == '0))
		else $error("new second did not start a clear sweep");
`endif

endmodule

// ----- rtl/psrd_seen_ram.sv -----
// ----------------------------------------------------------------------------
// Seen-port bitmap memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module psrd_seen_ram #(
	parameter int unsigned ADDR_W = 8
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [psrd_pkg::WORD_W-1:0] wdata,
	input  logic                        re,
	input  logic [ADDR_W-1:0]           raddr,
	output logic [psrd_pkg::WORD_W-1:0] rdata
);

	localparam int unsigned DEPTH = 2 ** ADDR_W;

	logic [psrd_pkg::WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- test/tb_port_scan_rate_detector_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Port scan rate detector testbench
// Streams packets through the detector and checks every drop and detection
// flag against a cycle-free bitmap predictor. Covers the reset defaults, scan
// bursts, empty and long windows, the top of the time range, back-pressure and
// random traffic under three idle patterns.
// ----------------------------------------------------------------------------
module tb_port_scan_rate_detector_unit;

	localparam int unsigned TABLE_SIZE     = psrd_pkg::PORT_TABLE_SIZE_DEF;
	localparam int          SETTLE_CYCLES  = 600;
	localparam int          STALL_CYCLES   = 300;
	localparam int          WATCHDOG_LIMIT = 6000;

	typedef logic [psrd_pkg::PORT_W-1:0]      port_t;
	typedef logic [psrd_pkg::TIME_W-1:0]      secs_t;
	typedef logic [psrd_pkg::MAX_NEW_W-1:0]   max_new_t;
	typedef logic [psrd_pkg::DURATION_W-1:0]  duration_t;
	typedef logic [psrd_pkg::CFG_DATA_W-1:0]  cfg_data_t;

	typedef struct packed {
		logic drop;
		logic newly;
	} verdict_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                pkt_valid = 1'b0;
	logic                                pkt_ready;
	logic                                is_tcp = 1'b0;
	port_t                               dst_port = '0;
	secs_t                               now_seconds = '0;
	logic                                res_valid;
	logic                                res_ready = 1'b0;
	logic                                drop;
	logic                                scan_newly_detected;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [psrd_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
	cfg_data_t                           cfg_data = '0;

	// predictor state
	bit                     tcp_seen [TABLE_SIZE];
	bit                     udp_seen [TABLE_SIZE];
	secs_t                  last_sec = '0;
	secs_t                  win_start = '0;
	max_new_t               port_count = '0;
	logic                   scan_flag = 1'b0;
	max_new_t               max_new = psrd_pkg::MAX_NEW_RESET;
	duration_t              duration = psrd_pkg::DURATION_RESET;

	verdict_t               verdict_q [$];
	verdict_t               exp_v;
	int                     errors = 0;
	int                     tx_idle_pct = 0;
	int                     rx_idle_pct = 0;
	int                     stall_reqs = 0;
	int                     stall_done = 0;
	int                     stall_left = 0;
	int                     idle_cycles = 0;
	secs_t                  clock_s = '0;

	port_scan_rate_detector_unit dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.pkt_valid           (pkt_valid),
		.pkt_ready           (pkt_ready),
		.is_tcp              (is_tcp),
		.dst_port            (dst_port),
		.now_seconds         (now_seconds),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.drop                (drop),
		.scan_newly_detected (scan_newly_detected),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Work out drop and detection for one packet and advance the predictor.
	function automatic verdict_t predict_verdict(logic tcp, port_t port, secs_t now);
		int unsigned slot;
		logic [psrd_pkg::TIME_W:0] window_end;
		verdict_t v;
		v = '0;
		slot = port % TABLE_SIZE;
		// seen port passes untouched, even inside a scan window
		if (tcp ? tcp_seen[slot] : udp_seen[slot])
			return v;
		if (tcp)
			tcp_seen[slot] = 1'b1;
		else
			udp_seen[slot] = 1'b1;
		if (now > last_sec) begin
			// new second: restart count, wipe both maps including this bit
			last_sec = now;
			port_count = max_new_t'(1);
			tcp_seen = '{default: 1'b0};
			udp_seen = '{default: 1'b0};
		end else begin
			if (port_count < psrd_pkg::COUNT_MAX)
				port_count = port_count + 1'b1;
			if (port_count > max_new) begin
				win_start = now;
				if (!scan_flag) begin
					scan_flag = 1'b1;
					v.newly = 1'b1;
				end
			end
		end
		// window end formed one bit wider so it never wraps
		window_end = {1'b0, win_start}
			+ {{(psrd_pkg::TIME_W+1-psrd_pkg::DURATION_W){1'b0}}, duration};
		if ({1'b0, now} < window_end)
			v.drop = 1'b1;
		else
			scan_flag = 1'b0;
		return v;
	endfunction

	// Predict on each packet transfer, check each result transfer, track writes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_valid && pkt_ready)
				verdict_q.push_back(predict_verdict(is_tcp, dst_port, now_seconds));
			if (res_valid && res_ready) begin
				if (verdict_q.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, actual drop=%0b newly=%0b",
						$time, drop, scan_newly_detected);
				end else begin
					exp_v = verdict_q.pop_front();
					if (drop !== exp_v.drop) begin
						errors++;
						$display("%0t drop mismatch: expected %0b actual %0b",
							$time, exp_v.drop, drop);
					end
					if (scan_newly_detected !== exp_v.newly) begin
						errors++;
						$display("%0t scan_newly_detected mismatch: expected %0b actual %0b",
							$time, exp_v.newly, scan_newly_detected);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == psrd_pkg::CFG_MAX_NEW_PORTS)
					max_new = cfg_data[psrd_pkg::MAX_NEW_W-1:0];
				else if (cfg_index == psrd_pkg::CFG_BLOCK_DURATION)
					duration = cfg_data[psrd_pkg::DURATION_W-1:0];
			end
		end
	end

	// Drive result ready: random idling, or a long hold-off on request.
	always @(negedge clk) begin
		if (stall_reqs != stall_done) begin
			stall_left = STALL_CYCLES;
			stall_done = stall_reqs;
		end
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else begin
			res_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Abort when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if ((pkt_valid && pkt_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("port_scan_rate_detector_unit verification failed");
			$finish;
		end
	end

	// Offer one packet, with random idle cycles ahead of it, and wait for its transfer.
	task automatic send_packet(input logic tcp, input port_t port, input secs_t now);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			pkt_valid <= 1'b0;
			@(negedge clk);
		end
		pkt_valid   <= 1'b1;
		is_tcp      <= tcp;
		dst_port    <= port;
		now_seconds <= now;
		@(posedge clk);
		while (!pkt_ready)
			@(posedge clk);
	endtask

	// Drop packet valid, wait for all results, then let a map sweep finish.
	task automatic drain_and_settle();
		@(negedge clk);
		pkt_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input psrd_pkg::cfg_reg_t idx, input cfg_data_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(input max_new_t max_v, input duration_t dur_v);
		drain_and_settle();
		write_reg(psrd_pkg::CFG_MAX_NEW_PORTS, cfg_data_t'(max_v));
		write_reg(psrd_pkg::CFG_BLOCK_DURATION, cfg_data_t'(dur_v));
	endtask

	// Reset defaults: early drop window, seen ports, aliasing, backwards time.
	task automatic test_reset_defaults();
		send_packet(1'b1, 16'd0, 32'd0);
		send_packet(1'b1, 16'd0, 32'd0);
		send_packet(1'b0, 16'd0, 32'd0);
		send_packet(1'b1, 16'd4096, 32'd0);
		send_packet(1'b0, 16'hFFFF, 32'd9);
		send_packet(1'b1, 16'd5, 32'd10);
		send_packet(1'b1, 16'd7, 32'd5);
	endtask

	// Burst above the limit, seen port in the window, expiry and a second detection.
	task automatic test_scan_burst();
		int k;
		configure(14'd3, 16'd2);
		for (k = 0; k < 6; k++)
			send_packet(1'b1, 16'(100 + k), 32'd100);
		send_packet(1'b1, 16'd101, 32'd100);
		send_packet(1'b0, 16'd200, 32'd101);
		send_packet(1'b0, 16'd201, 32'd102);
		for (k = 0; k < 3; k++)
			send_packet(1'b0, 16'(202 + k), 32'd102);
	endtask

	// Zero limit with an empty window, then a limit of 8192 and the largest duration.
	task automatic test_extreme_settings();
		configure(14'd0, 16'd0);
		send_packet(1'b1, 16'd1, 32'd200);
		send_packet(1'b1, 16'd2, 32'd200);
		send_packet(1'b1, 16'd3, 32'd200);
		configure(14'd8192, 16'hFFFF);
		send_packet(1'b0, 16'd9, 32'd300);
		send_packet(1'b0, 16'd10, 32'd300);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls.
	task automatic test_backpressure();
		int k;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		clock_s = clock_s + 1;
		send_packet(1'($urandom_range(1)), 16'($urandom), clock_s);
		stall_reqs++;
		for (k = 0; k < 40; k++)
			send_packet(1'($urandom_range(1)), 16'($urandom), clock_s);
		drain_and_settle();
	endtask

	// Window end past the top of the time range; runs last since time cannot move on.
	task automatic test_time_top();
		configure(14'd0, 16'hFFFF);
		send_packet(1'b1, 16'd11, 32'hFFFF_FFF0);
		send_packet(1'b1, 16'd12, 32'hFFFF_FFF0);
		send_packet(1'b0, 16'd13, 32'hFFFF_FFFF);
		send_packet(1'b0, 16'd14, 32'hFFFF_FFFF);
		send_packet(1'b0, 16'd14, 32'hFFFF_FFFF);
	endtask

	// Per-second bursts of new ports mixed with repeats, aliases and stale times.
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
		int sent;
		int round_sent;
		int burst_len;
		int cap;
		int k;
		int pick;
		max_new_t max_v;
		duration_t dur_v;
		logic [psrd_pkg::PORT_W:0] recent [$];
		logic [psrd_pkg::PORT_W:0] entry;
		logic tcp;
		port_t port;
		secs_t now;
		sent = 0;
		while (sent < n_items) begin
			// pick a setting, mostly small so scans and expiries happen often
			pick = $urandom_range(99);
			if (pick < 10)
				max_v = '0;
			else if (pick < 80)
				max_v = max_new_t'($urandom_range(1, 8));
			else if (pick < 92)
				max_v = max_new_t'($urandom_range(9, 400));
			else if (pick < 96)
				max_v = 14'd8192;
			else
				max_v = max_new_t'($urandom_range(0, 8192));
			pick = $urandom_range(99);
			if (pick < 5)
				dur_v = '0;
			else if (pick < 75)
				dur_v = duration_t'($urandom_range(1, 4));
			else if (pick < 90)
				dur_v = duration_t'($urandom_range(5, 40));
			else if (pick < 95)
				dur_v = 16'hFFFF;
			else
				dur_v = duration_t'($urandom_range(1, 65535));
			configure(max_v, dur_v);
			tx_idle_pct = tx_pct;
			rx_idle_pct = rx_pct;
			cap = (max_v < 16) ? max_v : 16;
			round_sent = 0;
			while (round_sent < 150 && sent < n_items) begin
				// advance the clock: mostly a few seconds, sometimes a big jump
				pick = $urandom_range(99);
				if (pick < 90)
					clock_s = clock_s + $urandom_range(1, 4);
				else if (pick < 98)
					clock_s = clock_s + $urandom_range(5, 1000);
				else
					clock_s = clock_s + $urandom_range(1 << 16, 1 << 22);
				recent.delete();
				burst_len = $urandom_range(1, cap + 6);
				for (k = 0; k < burst_len; k++) begin
					pick = $urandom_range(99);
					now = clock_s;
					if (pick < 60 || recent.size() == 0) begin
						tcp = 1'($urandom_range(1));
						port = 16'($urandom);
						recent.push_back({tcp, port});
					end else if (pick < 80) begin
						entry = recent[$urandom_range(recent.size() - 1)];
						{tcp, port} = entry;
					end else if (pick < 88) begin
						// same table slot through the upper port bits
						entry = recent[$urandom_range(recent.size() - 1)];
						{tcp, port} = entry;
						port = port ^ 16'($urandom_range(1, 15) << 12);
					end else begin
						tcp = 1'($urandom_range(1));
						port = 16'($urandom);
						now = clock_s - $urandom_range(0, 3);
					end
					send_packet(tcp, port, now);
					sent++;
					round_sent++;
				end
			end
		end
	endtask

	initial begin
		tx_idle_pct = 17;
		rx_idle_pct = 82;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_scan_burst();
		test_extreme_settings();
		clock_s = 32'h0000_1000;
		test_random_traffic(17, 82, 600);
		test_random_traffic(82, 17, 600);
		test_random_traffic(0, 0, 600);
		test_backpressure();
		test_time_top();

		drain_and_settle();
		if (errors == 0)
			$display("port_scan_rate_detector_unit verification clean");
		else
			$display("port_scan_rate_detector_unit verification failed");
		$finish;
	end

endmodule
